// ===== rtl/asq_pkg.sv =====
package asq_pkg;

    localparam int QUEUE_DEPTH_DEF  = 32;
    localparam int ACTIVE_DEPTH_DEF = 4;
    localparam int MAX_PICK         = 4;
    localparam int KEY_W            = 20;
    localparam int PRIO_W           = 24;
    localparam int FRAME_W          = 32;
    localparam int WEIGHT_W         = 16;
    localparam int PROD_W           = WEIGHT_W + FRAME_W;
    localparam int SCORE_W          = PROD_W + 1;

    localparam logic [WEIGHT_W-1:0] AGE_WEIGHT_RST = 16'd328;

    typedef enum logic [1:0] {
        OPC_REQUEST = 2'd0,
        OPC_UNMAP   = 2'd1,
        OPC_FINISH  = 2'd2,
        OPC_TICK    = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_DISPATCH = 2'd0,
        KIND_CANCEL   = 2'd1,
        KIND_DROP     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        CELL_NOP        = 3'd0,
        CELL_RAISE      = 3'd1,
        CELL_APPEND     = 3'd2,
        CELL_REMOVE_KEY = 3'd3,
        CELL_REMOVE_SEL = 3'd4,
        CELL_MARK       = 3'd5
    } t_cell_op;

    typedef struct packed {
        logic              valid;
        logic              sel;
        logic [KEY_W-1:0]  key;
        logic [PRIO_W-1:0] prio;
        logic [FRAME_W-1:0] frame;
    } t_entry;

    typedef struct packed {
        t_cell_op           op;
        logic [KEY_W-1:0]   key;
        logic [PRIO_W-1:0]  prio;
        logic [FRAME_W-1:0] frame;
    } t_qcmd;

endpackage

// ===== rtl/asq_cell.sv =====
module asq_cell
    import asq_pkg::*;
#(
    parameter int IW  = 5,
    parameter int IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_qcmd         i_cmd,
    input  logic [IW-1:0] i_idx,
    input  logic          i_prev_valid,
    input  logic          i_carry,
    input  t_entry        i_next,
    output t_entry        o_ent,
    output logic          o_carry,
    output logic          o_match
);

    logic               r_valid, n_valid;
    logic               r_sel, n_sel;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [PRIO_W-1:0]  r_prio, n_prio;
    logic [FRAME_W-1:0] r_frame, n_frame;
    logic               hit;
    logic               shift;

    assign o_match = r_valid && (r_key == i_cmd.key);
    assign hit     = ((i_cmd.op == CELL_REMOVE_KEY) && o_match) ||
                     ((i_cmd.op == CELL_REMOVE_SEL) && r_sel);
    assign shift   = i_carry || hit;
    assign o_carry = shift;

    assign o_ent = '{valid: r_valid, sel: r_sel, key: r_key, prio: r_prio, frame: r_frame};

    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        n_key   = r_key;
        n_prio  = r_prio;
        n_frame = r_frame;
        if (shift) begin
            // Close the gap: take the neighbor's contents.
            n_valid = i_next.valid;
            n_sel   = i_next.sel;
            n_key   = i_next.key;
            n_prio  = i_next.prio;
            n_frame = i_next.frame;
        end else begin
            unique case (i_cmd.op)
                CELL_RAISE: begin
                    if (o_match && (i_cmd.prio > r_prio)) n_prio = i_cmd.prio;
                end
                CELL_APPEND: begin
                    if (!r_valid && i_prev_valid) begin
                        n_valid = 1'b1;
                        n_sel   = 1'b0;
                        n_key   = i_cmd.key;
                        n_prio  = i_cmd.prio;
                        n_frame = i_cmd.frame;
                    end
                end
                CELL_MARK: begin
                    if (i_idx == IW'(IDX)) n_sel = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
        r_key   <= n_key;
        r_prio  <= n_prio;
        r_frame <= n_frame;
    end

endmodule

// ===== rtl/asq_queue.sv =====
module asq_queue
    import asq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_qcmd         i_cmd,
    input  logic [IW-1:0] i_idx,
    input  logic [IW-1:0] i_rd_idx,
    output t_entry        o_rd,
    output logic          o_found,
    output logic          o_full,
    output logic          o_nonempty,
    output logic          o_any_sel
);

    t_entry             w_ent   [DEPTH];
    logic [DEPTH:0]     w_carry;
    logic [DEPTH-1:0]   w_match;
    logic [DEPTH-1:0]   w_valid;
    logic [DEPTH-1:0]   w_sel;

    assign w_carry[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_entry nxt;
        logic   prev_v;
        if (g == DEPTH - 1) begin : g_tail
            assign nxt = '0;
        end else begin : g_mid
            assign nxt = w_ent[g+1];
        end
        if (g == 0) begin : g_head
            assign prev_v = 1'b1;
        end else begin : g_body
            assign prev_v = w_ent[g-1].valid;
        end
        asq_cell #(.IW(IW), .IDX(g)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (i_cmd),
            .i_idx        (i_idx),
            .i_prev_valid (prev_v),
            .i_carry      (w_carry[g]),
            .i_next       (nxt),
            .o_ent        (w_ent[g]),
            .o_carry      (w_carry[g+1]),
            .o_match      (w_match[g])
        );
        assign w_valid[g] = w_ent[g].valid;
        assign w_sel[g]   = w_ent[g].sel;
    end

    assign o_rd       = w_ent[i_rd_idx];
    assign o_found    = |w_match;
    assign o_full     = w_valid[DEPTH-1];
    assign o_nonempty = w_valid[0];
    assign o_any_sel  = |w_sel;

endmodule

// ===== rtl/asq_rank.sv =====
module asq_rank
    import asq_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [WEIGHT_W-1:0]            i_weight,
    input  logic [FRAME_W-1:0]             i_frame_now,
    input  t_entry                         i_rd,
    output logic [IW-1:0]                  o_rd_idx,
    output logic                           o_done,
    output logic [2:0]                     o_count,
    output logic [MAX_PICK-1:0][IW-1:0]    o_pick
);

    logic                r_busy, r_run, r_g1, r_g2;
    logic [IW-1:0]       r_idx, r_i1, r_i2;
    logic                r_v1, r_v2;
    logic [PRIO_W-1:0]   r_p1, r_p2;
    logic [FRAME_W-1:0]  r_a1;
    logic [PROD_W-1:0]   r_m2;
    logic [MAX_PICK-1:0] r_lv, n_lv;
    logic [SCORE_W-1:0]  r_ls [MAX_PICK];
    logic [SCORE_W-1:0]  n_ls [MAX_PICK];
    logic [IW-1:0]       r_li [MAX_PICK];
    logic [IW-1:0]       n_li [MAX_PICK];
    logic [SCORE_W-1:0]  score;
    logic [2:0]          pos;
    logic [2:0]          cnt;

    assign o_rd_idx = r_idx;
    assign o_done   = r_busy && !r_run && !r_g1 && !r_g2;
    assign score    = SCORE_W'(r_m2) + SCORE_W'(r_p2);

    // Stable top list: a new entry goes behind every kept entry of equal score.
    always_comb begin
        pos = 3'd0;
        cnt = 3'd0;
        for (int k = 0; k < MAX_PICK; k++) begin
            if (r_lv[k] && (r_ls[k] >= score)) pos = pos + 3'd1;
            if (r_lv[k]) cnt = cnt + 3'd1;
        end
        for (int k = 0; k < MAX_PICK; k++) begin
            n_lv[k] = r_lv[k];
            n_ls[k] = r_ls[k];
            n_li[k] = r_li[k];
            if (r_g2 && r_v2) begin
                if (3'(k) == pos) begin
                    n_lv[k] = 1'b1;
                    n_ls[k] = score;
                    n_li[k] = r_i2;
                end else if ((3'(k) > pos) && (k > 0)) begin
                    n_lv[k] = r_lv[k-1];
                    n_ls[k] = r_ls[k-1];
                    n_li[k] = r_li[k-1];
                end
            end
        end
        for (int k = 0; k < MAX_PICK; k++) o_pick[k] = r_li[k];
        o_count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_run  <= 1'b0;
            r_g1   <= 1'b0;
            r_g2   <= 1'b0;
            r_lv   <= '0;
            r_idx  <= '0;
        end else begin
            r_g1 <= r_run;
            r_g2 <= r_g1;
            if (i_start) begin
                r_busy <= 1'b1;
                r_run  <= 1'b1;
                r_idx  <= '0;
                r_lv   <= '0;
            end else begin
                if (o_done) r_busy <= 1'b0;
                if (r_run) begin
                    if (r_idx == IW'(DEPTH - 1)) r_run <= 1'b0;
                    r_idx <= r_idx + IW'(1);
                end
                r_lv <= n_lv;
            end
        end
        r_v1 <= i_rd.valid;
        r_i1 <= r_idx;
        r_p1 <= i_rd.prio;
        r_a1 <= i_frame_now - i_rd.frame;
        r_v2 <= r_v1;
        r_i2 <= r_i1;
        r_p2 <= r_p1;
        r_m2 <= PROD_W'(i_weight) * PROD_W'(r_a1);
        for (int k = 0; k < MAX_PICK; k++) begin
            r_ls[k] <= n_ls[k];
            r_li[k] <= n_li[k];
        end
    end

endmodule

// ===== rtl/two_queue_aged_update_scheduler.sv =====
// Channel   Direction  Handshake          Word
// input     in         i_valid / o_stall  opcode, probe key, priority, tick fields
// output    out        o_valid / i_stall  kind, probe key, queue, budget, last
// config    in         i_wr_en            i_wr_data = age weight, unsigned Q16.0
//
// Request, unmap and finish each take one state of their own, then return to idle.
// A frame tick scans the bake queue and then the refresh queue with one score
// pipeline, then emits one word per cycle while the output is not stalled, then
// compacts one gap per cycle (at most four).
// Reset is synchronous and clears the queue valid bits, the active set and the
// frame counter. An output stall holds a valid word and any state that loads one.
module two_queue_aged_update_scheduler
    import asq_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int ACTIVE_DEPTH = ACTIVE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_opcode,
    input  logic [3:0]          i_world_index,
    input  logic [15:0]         i_probe_index,
    input  logic [23:0]         i_priority_req,
    input  logic                i_first_bake,
    input  logic [2:0]          i_free_slots,
    input  logic                i_bake_in_progress,
    input  logic                i_wr_en,
    input  logic [WEIGHT_W-1:0] i_wr_data,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [1:0]          o_kind,
    output logic [3:0]          o_out_world,
    output logic [15:0]         o_out_probe,
    output logic                o_out_first_bake,
    output logic                o_sharing_budget,
    output logic                o_last
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int AW = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;

    // The sequencer is one-hot; every item starts from idle.
    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_REQ     = 8'b0000_0010,
        S_UNMAP   = 8'b0000_0100,
        S_FIN     = 8'b0000_1000,
        S_SCAN_B  = 8'b0001_0000,
        S_SCAN_R  = 8'b0010_0000,
        S_EMIT    = 8'b0100_0000,
        S_COMPACT = 8'b1000_0000
    } t_state;

    t_state               r_state, n_state;
    logic [WEIGHT_W-1:0]  r_age_weight;
    logic [FRAME_W-1:0]   r_frame_cnt;
    logic [KEY_W-1:0]     r_key;
    logic [PRIO_W-1:0]    r_prio;
    logic                 r_fb;
    logic [2:0]           r_slots;
    logic                 r_bake_run;
    logic                 r_rpres;
    logic                 r_scan_bake;
    logic [MAX_PICK-1:0][IW-1:0] r_bpick;
    logic [2:0]           r_bcnt;
    logic [2:0]           r_nb, r_k, r_e;

    logic                 r_av [ACTIVE_DEPTH];
    logic [KEY_W-1:0]     r_ak [ACTIVE_DEPTH];

    logic                 r_ov;
    t_kind                r_okind;
    logic [KEY_W-1:0]     r_okey;
    logic                 r_ofb, r_osb, r_olast;

    logic                 accept, out_free;
    t_qcmd                b_cmd, f_cmd;
    logic [IW-1:0]        b_idx, f_idx, b_rd_idx, f_rd_idx;
    t_entry               b_rd, f_rd, rank_rd;
    logic                 b_found, b_full, b_nonempty, b_any_sel;
    logic                 f_found, f_full, f_nonempty, f_any_sel;
    logic                 rank_start, rank_done;
    logic [IW-1:0]        rank_idx;
    logic [2:0]           rank_cnt;
    logic [MAX_PICK-1:0][IW-1:0] rank_pick;

    logic [2:0]           n_slots, nb, nr, rem;
    logic                 e_bake, e_last;
    logic [2:0]           e_sub;
    t_entry               e_ent;

    logic [ACTIVE_DEPTH-1:0] hit_in, hit_e;
    logic                 free_ok;
    logic [AW-1:0]        free_at;

    logic                 load;
    t_kind                ld_kind;
    logic [KEY_W-1:0]     ld_key;
    logic                 ld_fb, ld_sb, ld_last;
    logic                 act_clear, act_insert, frame_inc;

    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_ov || !i_stall;

    asq_queue #(.DEPTH(QUEUE_DEPTH), .IW(IW)) u_bake (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (b_cmd),
        .i_idx      (b_idx),
        .i_rd_idx   (b_rd_idx),
        .o_rd       (b_rd),
        .o_found    (b_found),
        .o_full     (b_full),
        .o_nonempty (b_nonempty),
        .o_any_sel  (b_any_sel)
    );

    asq_queue #(.DEPTH(QUEUE_DEPTH), .IW(IW)) u_refresh (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (f_cmd),
        .i_idx      (f_idx),
        .i_rd_idx   (f_rd_idx),
        .o_rd       (f_rd),
        .o_found    (f_found),
        .o_full     (f_full),
        .o_nonempty (f_nonempty),
        .o_any_sel  (f_any_sel)
    );

    // One score pipeline serves both queues; the bake queue is ranked with zero
    // weight so that its score is the priority alone.
    asq_rank #(.DEPTH(QUEUE_DEPTH), .IW(IW)) u_rank (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (rank_start),
        .i_weight    (r_scan_bake ? '0 : r_age_weight),
        .i_frame_now (r_frame_cnt),
        .i_rd        (rank_rd),
        .o_rd_idx    (rank_idx),
        .o_done      (rank_done),
        .o_count     (rank_cnt),
        .o_pick      (rank_pick)
    );

    assign rank_start = (accept && (t_opcode'(i_opcode) == OPC_TICK)) ||
                        ((r_state == S_SCAN_B) && rank_done);
    assign rank_rd    = r_scan_bake ? b_rd : f_rd;

    // Dispatch bookkeeping: bakes first, then refreshes, up to four slots.
    // An empty bake queue yields no bake dispatch whatever the scan reports.
    assign n_slots = (r_slots > 3'(MAX_PICK)) ? 3'(MAX_PICK) : r_slots;
    assign nb      = !b_nonempty ? 3'd0 : ((r_bcnt < n_slots) ? r_bcnt : n_slots);
    assign rem     = n_slots - nb;
    assign nr      = (rank_cnt < rem) ? rank_cnt : rem;

    assign e_bake   = (r_e < r_nb);
    assign e_sub    = e_bake ? r_e : (r_e - r_nb);
    assign e_last   = (3'(r_e + 3'd1) == r_k);
    assign b_rd_idx = (r_state == S_SCAN_B) ? rank_idx : r_bpick[e_sub[1:0]];
    assign f_rd_idx = (r_state == S_SCAN_R) ? rank_idx : rank_pick[e_sub[1:0]];
    assign e_ent    = e_bake ? b_rd : f_rd;

    always_comb begin
        free_ok = 1'b0;
        free_at = '0;
        for (int a = 0; a < ACTIVE_DEPTH; a++) begin
            hit_in[a] = r_av[a] && (r_ak[a] == r_key);
            hit_e[a]  = r_av[a] && (r_ak[a] == e_ent.key);
        end
        for (int a = ACTIVE_DEPTH - 1; a >= 0; a--) begin
            if (!r_av[a]) begin
                free_ok = 1'b1;
                free_at = AW'(a);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        b_cmd      = '{op: CELL_NOP, key: r_key, prio: r_prio, frame: r_frame_cnt};
        f_cmd      = b_cmd;
        b_idx      = r_bpick[e_sub[1:0]];
        f_idx      = rank_pick[e_sub[1:0]];
        load       = 1'b0;
        ld_kind    = KIND_DISPATCH;
        ld_key     = r_key;
        ld_fb      = 1'b0;
        ld_sb      = 1'b0;
        ld_last    = 1'b1;
        act_clear  = 1'b0;
        act_insert = 1'b0;
        frame_inc  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_opcode'(i_opcode))
                        OPC_REQUEST: n_state = S_REQ;
                        OPC_UNMAP:   n_state = S_UNMAP;
                        OPC_FINISH:  n_state = S_FIN;
                        OPC_TICK:    n_state = S_SCAN_B;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_REQ: begin
                if (r_fb ? b_found : f_found) begin
                    if (r_fb) b_cmd.op = CELL_RAISE;
                    else      f_cmd.op = CELL_RAISE;
                    n_state = S_IDLE;
                end else if (r_fb ? b_full : f_full) begin
                    // Queue full: the request is dropped whole and reported.
                    if (out_free) begin
                        load    = 1'b1;
                        ld_kind = KIND_DROP;
                        ld_fb   = r_fb;
                        n_state = S_IDLE;
                    end
                end else begin
                    if (r_fb) begin
                        b_cmd.op = CELL_APPEND;
                        f_cmd.op = CELL_REMOVE_KEY;
                    end else begin
                        f_cmd.op = CELL_APPEND;
                        b_cmd.op = CELL_REMOVE_KEY;
                    end
                    n_state = S_IDLE;
                end
            end
            S_UNMAP: begin
                if (!(|hit_in) || out_free) begin
                    b_cmd.op = CELL_REMOVE_KEY;
                    f_cmd.op = CELL_REMOVE_KEY;
                    if (|hit_in) begin
                        act_clear = 1'b1;
                        load      = 1'b1;
                        ld_kind   = KIND_CANCEL;
                    end
                    n_state = S_IDLE;
                end
            end
            S_FIN: begin
                act_clear = 1'b1;
                n_state   = S_IDLE;
            end
            S_SCAN_B: begin
                if (rank_done) n_state = S_SCAN_R;
            end
            S_SCAN_R: begin
                if (rank_done) begin
                    if ((nb + nr) == 3'd0) n_state = S_COMPACT;
                    else                   n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load       = 1'b1;
                    act_insert = 1'b1;
                    ld_kind    = KIND_DISPATCH;
                    ld_key     = e_ent.key;
                    ld_fb      = e_bake;
                    ld_sb      = e_bake ? r_rpres : (r_bake_run || (r_nb != 3'd0));
                    ld_last    = e_last;
                    if (e_bake) b_cmd.op = CELL_MARK;
                    else        f_cmd.op = CELL_MARK;
                    if (e_last) n_state = S_COMPACT;
                end
            end
            S_COMPACT: begin
                // Each pass closes the first gap left by a dispatched entry.
                b_cmd.op = CELL_REMOVE_SEL;
                f_cmd.op = CELL_REMOVE_SEL;
                if (!b_any_sel && !f_any_sel) begin
                    frame_inc = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_age_weight <= AGE_WEIGHT_RST;
            r_frame_cnt  <= '0;
            r_ov         <= 1'b0;
            r_scan_bake  <= 1'b0;
            for (int a = 0; a < ACTIVE_DEPTH; a++) r_av[a] <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_wr_en) r_age_weight <= i_wr_data;
            if (frame_inc) r_frame_cnt <= r_frame_cnt + FRAME_W'(1);
            if (load) r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            if (accept) r_scan_bake <= 1'b1;
            else if ((r_state == S_SCAN_B) && rank_done) r_scan_bake <= 1'b0;
            for (int a = 0; a < ACTIVE_DEPTH; a++) begin
                if (act_clear && hit_in[a]) r_av[a] <= 1'b0;
            end
            if (act_insert && !(|hit_e) && free_ok) r_av[free_at] <= 1'b1;
        end

        if (act_insert && !(|hit_e) && free_ok) r_ak[free_at] <= e_ent.key;

        if (accept) begin
            r_key      <= {i_world_index, i_probe_index};
            r_prio     <= i_priority_req;
            r_fb       <= i_first_bake;
            r_slots    <= i_free_slots;
            r_bake_run <= i_bake_in_progress;
            r_rpres    <= f_nonempty;
        end
        if ((r_state == S_SCAN_B) && rank_done) begin
            r_bpick <= rank_pick;
            r_bcnt  <= rank_cnt;
        end
        if ((r_state == S_SCAN_R) && rank_done) begin
            r_nb <= nb;
            r_k  <= nb + nr;
            r_e  <= 3'd0;
        end else if ((r_state == S_EMIT) && out_free) begin
            r_e <= r_e + 3'd1;
        end
        if (load) begin
            r_okind <= ld_kind;
            r_okey  <= ld_key;
            r_ofb   <= ld_fb;
            r_osb   <= ld_sb;
            r_olast <= ld_last;
        end
    end

    assign o_valid          = r_ov;
    assign o_kind           = r_okind;
    assign o_out_world      = r_okey[KEY_W-1:16];
    assign o_out_probe      = r_okey[15:0];
    assign o_out_first_bake = r_ofb;
    assign o_sharing_budget = r_osb;
    assign o_last           = r_olast;

endmodule

// ===== dv/testbench.sv =====
module testbench;
    import asq_pkg::*;

    localparam int QDEPTH      = 32;
    localparam int ACTIVE_N    = 4;
    localparam int DRAIN_WAIT  = 120;
    localparam int CYCLE_LIMIT = 600000;

    // One input word and one result word, typed at the widths of the ports.
    typedef struct {
        t_opcode     op;
        logic [3:0]  world;
        logic [15:0] probe;
        logic [23:0] prio;
        logic        fb;
        logic [2:0]  slots;
        logic        bip;
    } t_in_word;

    typedef struct {
        t_kind       kind;
        logic [3:0]  world;
        logic [15:0] probe;
        logic        fb;
        logic        sb;
        logic        last;
    } t_out_word;

    // A directed row carries an optional hand-written result for the items
    // whose single result is obvious; the others are left to the predictor.
    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word t;
    } t_row;

    typedef struct {
        logic [19:0] key;
        logic [23:0] prio;
        logic [31:0] frame;
    } t_q_entry;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_opcode;
    logic [3:0]          i_world_index;
    logic [15:0]         i_probe_index;
    logic [23:0]         i_priority_req;
    logic                i_first_bake;
    logic [2:0]          i_free_slots;
    logic                i_bake_in_progress;
    logic                i_wr_en;
    logic [WEIGHT_W-1:0] i_wr_data;
    logic                o_valid;
    logic                i_stall;
    logic [1:0]          o_kind;
    logic [3:0]          o_out_world;
    logic [15:0]         o_out_probe;
    logic                o_out_first_bake;
    logic                o_sharing_budget;
    logic                o_last;

    two_queue_aged_update_scheduler u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_opcode           (i_opcode),
        .i_world_index      (i_world_index),
        .i_probe_index      (i_probe_index),
        .i_priority_req     (i_priority_req),
        .i_first_bake       (i_first_bake),
        .i_free_slots       (i_free_slots),
        .i_bake_in_progress (i_bake_in_progress),
        .i_wr_en            (i_wr_en),
        .i_wr_data          (i_wr_data),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_kind             (o_kind),
        .o_out_world        (o_out_world),
        .o_out_probe        (o_out_probe),
        .o_out_first_bake   (o_out_first_bake),
        .o_sharing_budget   (o_sharing_budget),
        .o_last             (o_last)
    );

    // Shadow state of the scheduler: both queues kept in enqueue order, the
    // set of probes with an update in flight, the frame counter and the gain.
    t_q_entry    bake_q[$];
    t_q_entry    refresh_q[$];
    logic [19:0] active_key[ACTIVE_N];
    bit          active_ok[ACTIVE_N];
    logic [31:0] frame_ctr;
    logic [15:0] age_gain;

    t_out_word   step_results[$];
    t_out_word   pending_results[$];
    int          errors;
    int          cycles;

    // Sender burst bookkeeping.
    int          burst_left;
    bit          valid_high;

    logic [19:0] key_pool[10];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what);
        $display("[%0d] mismatch: %s", cycles, what);
        errors++;
    endtask

    function automatic int find_queued(input bit bake, input logic [19:0] key);
        int i;
        if (bake) begin
            for (i = 0; i < bake_q.size(); i++)
                if (bake_q[i].key == key) return i;
        end else begin
            for (i = 0; i < refresh_q.size(); i++)
                if (refresh_q[i].key == key) return i;
        end
        return -1;
    endfunction

    function automatic int find_active(input logic [19:0] key);
        int i;
        for (i = 0; i < ACTIVE_N; i++)
            if (active_ok[i] && active_key[i] == key) return i;
        return -1;
    endfunction

    function automatic void add_result(input t_kind kind, input logic [19:0] key,
                                       input logic fb, input logic sb);
        t_out_word r;
        r.kind  = kind;
        r.world = key[19:16];
        r.probe = key[15:0];
        r.fb    = fb;
        r.sb    = sb;
        r.last  = 1'b0;
        step_results.push_back(r);
    endfunction

    // Advances the shadow state by one accepted word and leaves the results
    // it causes in step_results, the final one marked last.
    function automatic void advance_scheduler(input t_in_word w);
        logic [19:0] key;
        t_q_entry    e;
        int          idx;
        int          n;
        int          best;
        int          i;
        bit          bsel[QDEPTH];
        bit          rsel[QDEPTH];
        bit          refresh_present;
        bit          bake_started;
        logic [19:0] sent[$];
        logic [31:0] age;
        logic [63:0] s;
        logic [63:0] best_s;
        key = {w.world, w.probe};
        step_results.delete();
        case (w.op)
            OPC_REQUEST: begin
                idx = find_queued(w.fb, key);
                if (idx >= 0) begin
                    // A repeat request can only raise the priority.
                    if (w.fb) begin
                        if (w.prio > bake_q[idx].prio) bake_q[idx].prio = w.prio;
                    end else begin
                        if (w.prio > refresh_q[idx].prio) refresh_q[idx].prio = w.prio;
                    end
                end else if ((w.fb ? bake_q.size() : refresh_q.size()) >= QDEPTH) begin
                    add_result(KIND_DROP, key, w.fb, 1'b0);
                end else begin
                    e.key   = key;
                    e.prio  = w.prio;
                    e.frame = frame_ctr;
                    idx = find_queued(!w.fb, key);
                    if (w.fb) begin
                        if (idx >= 0) refresh_q.delete(idx);
                        bake_q.push_back(e);
                    end else begin
                        if (idx >= 0) bake_q.delete(idx);
                        refresh_q.push_back(e);
                    end
                end
            end
            OPC_UNMAP: begin
                idx = find_queued(1'b1, key);
                if (idx >= 0) bake_q.delete(idx);
                idx = find_queued(1'b0, key);
                if (idx >= 0) refresh_q.delete(idx);
                idx = find_active(key);
                if (idx >= 0) begin
                    active_ok[idx] = 1'b0;
                    add_result(KIND_CANCEL, key, 1'b0, 1'b0);
                end
            end
            OPC_FINISH: begin
                idx = find_active(key);
                if (idx >= 0) active_ok[idx] = 1'b0;
            end
            default: begin
                n = (w.slots > 4) ? 4 : int'(w.slots);
                refresh_present = refresh_q.size() > 0;
                bake_started = 1'b0;
                for (i = 0; i < QDEPTH; i++) begin
                    bsel[i] = 1'b0;
                    rsel[i] = 1'b0;
                end
                while (sent.size() < n) begin
                    // Bakes first, by priority; ties keep enqueue order.
                    best = -1;
                    for (i = 0; i < bake_q.size(); i++)
                        if (!bsel[i] && (best < 0 || bake_q[i].prio > bake_q[best].prio))
                            best = i;
                    if (best >= 0) begin
                        bsel[best] = 1'b1;
                        sent.push_back(bake_q[best].key);
                        add_result(KIND_DISPATCH, bake_q[best].key, 1'b1, refresh_present);
                        bake_started = 1'b1;
                        continue;
                    end
                    // Refreshes score priority plus the gain times the frames waited.
                    best = -1;
                    best_s = '0;
                    for (i = 0; i < refresh_q.size(); i++) begin
                        if (rsel[i]) continue;
                        age = frame_ctr - refresh_q[i].frame;
                        s = 64'(refresh_q[i].prio) + 64'(age_gain) * 64'(age);
                        if (best < 0 || s > best_s) begin
                            best = i;
                            best_s = s;
                        end
                    end
                    if (best < 0) break;
                    rsel[best] = 1'b1;
                    sent.push_back(refresh_q[best].key);
                    add_result(KIND_DISPATCH, refresh_q[best].key, 1'b0,
                               w.bip || bake_started);
                end
                for (i = QDEPTH - 1; i >= 0; i--) begin
                    if (bsel[i]) bake_q.delete(i);
                    if (rsel[i]) refresh_q.delete(i);
                end
                // Record in-flight probes; a full set simply forgets the rest.
                foreach (sent[j]) begin
                    if (find_active(sent[j]) < 0) begin
                        for (i = 0; i < ACTIVE_N; i++) begin
                            if (!active_ok[i]) begin
                                active_ok[i] = 1'b1;
                                active_key[i] = sent[j];
                                break;
                            end
                        end
                    end
                end
                frame_ctr = frame_ctr + 32'd1;
            end
        endcase
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
    endfunction

    // Presents one word, holds it until it is taken, then updates the shadow
    // state. The sender runs in bursts with random gaps between them.
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word t);
        int gap;
        i_valid            <= 1'b1;
        valid_high          = 1'b1;
        i_opcode           <= w.op;
        i_world_index      <= w.world;
        i_probe_index      <= w.probe;
        i_priority_req     <= w.prio;
        i_first_bake       <= w.fb;
        i_free_slots       <= w.slots;
        i_bake_in_progress <= w.bip;
        do @(posedge i_clk); while (o_stall);
        advance_scheduler(w);
        if (typed)
            pending_results.push_back(t);
        else
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 14);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
            if (gap > 0) begin
                i_valid <= 1'b0;
                valid_high = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_plain(input t_in_word w);
        t_out_word none;
        none = '{KIND_DISPATCH, 4'd0, 16'd0, 1'b0, 1'b0, 1'b0};
        send_word(w, 1'b0, none);
    endtask

    // Lowers valid and waits until every expected word has come back, then for
    // longer than an item without any result can keep the block busy.
    task automatic drain;
        if (valid_high) begin
            i_valid <= 1'b0;
            valid_high = 1'b0;
        end
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_gain(input logic [15:0] v);
        i_wr_en   <= 1'b1;
        i_wr_data <= v;
        @(posedge i_clk);
        i_wr_en   <= 1'b0;
        age_gain = v;
        @(posedge i_clk);
    endtask

    task automatic random_phase(input int count);
        t_in_word w;
        int       r;
        int       k;
        foreach (key_pool[k])
            key_pool[k] = 20'($urandom);
        repeat (count) begin
            r = $urandom_range(0, 99);
            k = $urandom_range(0, 9);
            w.op    = OPC_REQUEST;
            w.world = key_pool[k][19:16];
            w.probe = key_pool[k][15:0];
            w.prio  = 24'($urandom);
            w.fb    = 1'($urandom);
            w.slots = 3'($urandom);
            w.bip   = 1'($urandom);
            if ($urandom_range(0, 3) == 0)
                w.prio = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
            if (r < 45)
                w.op = OPC_REQUEST;
            else if (r < 55)
                w.op = OPC_UNMAP;
            else if (r < 70)
                w.op = OPC_FINISH;
            else if (r < 92)
                w.op = OPC_TICK;
            else begin
                // Noise: any opcode on a randomly drawn probe, not taken from the pool.
                w.op    = t_opcode'($urandom_range(0, 3));
                w.world = 4'($urandom);
                w.probe = 16'($urandom);
            end
            send_plain(w);
        end
    endtask

    // Receiver: stalls never, one time in four or seven times in ten, by a mode it
    // redraws at random, and checks each taken word against the oldest expectation.
    int   stall_mode;
    always @(posedge i_clk) begin
        t_out_word e;
        cycles <= cycles + 1;
        if (cycles % 64 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       i_stall <= 1'b0;
            1:       i_stall <= ($urandom_range(0, 3) == 0);
            default: i_stall <= ($urandom_range(0, 9) < 7);
        endcase
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected word kind %0d world %0h probe %0h",
                                 o_kind, o_out_world, o_out_probe));
            end else begin
                e = pending_results.pop_front();
                if (o_kind != e.kind)
                    report($sformatf("kind %0d, expected %0d", o_kind, e.kind));
                if (o_out_world != e.world)
                    report($sformatf("world %0h, expected %0h", o_out_world, e.world));
                if (o_out_probe != e.probe)
                    report($sformatf("probe %0h, expected %0h", o_out_probe, e.probe));
                if (o_out_first_bake != e.fb)
                    report($sformatf("first_bake %0b, expected %0b", o_out_first_bake, e.fb));
                if (o_sharing_budget != e.sb)
                    report($sformatf("sharing_budget %0b, expected %0b",
                                     o_sharing_budget, e.sb));
                if (o_last != e.last)
                    report($sformatf("last %0b, expected %0b", o_last, e.last));
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench failed");
            $finish;
        end
    end

    t_row        rows[$];
    t_in_word    fw;
    logic [19:0] fill_keys[$];

    initial begin
        errors = 0;
        cycles = 0;
        stall_mode = 0;
        burst_left = 4;
        valid_high = 1'b0;
        frame_ctr = '0;
        age_gain = AGE_WEIGHT_RST;
        foreach (active_ok[i]) active_ok[i] = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_stall <= 1'b0;
        i_opcode <= OPC_REQUEST;
        i_world_index <= '0;
        i_probe_index <= '0;
        i_priority_req <= '0;
        i_first_bake <= 1'b0;
        i_free_slots <= '0;
        i_bake_in_progress <= 1'b0;
        i_wr_en <= 1'b0;
        i_wr_data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows: empty tick, top corners, raise and no-lower,
        // moves between queues, equal scores, too many slots, unknown finish.
        rows = '{
            '{'{OPC_TICK,    4'h0, 16'h0000, 24'h000000, 1'b0, 3'd4, 1'b0}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_REQUEST, 4'hF, 16'hFFFF, 24'hFFFFFF, 1'b1, 3'd0, 1'b0}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_TICK,    4'h0, 16'h0000, 24'h000000, 1'b0, 3'd1, 1'b0}, 1'b1,
              '{KIND_DISPATCH, 4'hF, 16'hFFFF, 1'b1, 1'b0, 1'b1}},
            '{'{OPC_UNMAP,   4'hF, 16'hFFFF, 24'h000000, 1'b0, 3'd0, 1'b0}, 1'b1,
              '{KIND_CANCEL, 4'hF, 16'hFFFF, 1'b0, 1'b0, 1'b1}},
            '{'{OPC_FINISH,  4'h3, 16'h1234, 24'h000000, 1'b0, 3'd0, 1'b0}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_REQUEST, 4'h0, 16'h0000, 24'h000000, 1'b0, 3'd0, 1'b0}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_REQUEST, 4'h0, 16'h0000, 24'h000100, 1'b0, 3'd0, 1'b0}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_REQUEST, 4'h0, 16'h0000, 24'h000050, 1'b0, 3'd0, 1'b0}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_REQUEST, 4'h1, 16'h0001, 24'h000200, 1'b0, 3'd0, 1'b0}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_REQUEST, 4'h1, 16'h0001, 24'h000010, 1'b1, 3'd0, 1'b0}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_REQUEST, 4'h2, 16'h5555, 24'h000100, 1'b0, 3'd0, 1'b0}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_TICK,    4'h0, 16'h0000, 24'h000000, 1'b0, 3'd7, 1'b1}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_FINISH,  4'h1, 16'h0001, 24'h000000, 1'b0, 3'd0, 1'b0}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_UNMAP,   4'h0, 16'h0000, 24'h000000, 1'b0, 3'd0, 1'b0}, 1'b1,
              '{KIND_CANCEL, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b1}},
            '{'{OPC_REQUEST, 4'hA, 16'hAAAA, 24'h800000, 1'b0, 3'd0, 1'b0}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_TICK,    4'h0, 16'h0000, 24'h000000, 1'b0, 3'd0, 1'b1}, 1'b0,
              '{KIND_DISPATCH, 4'h0, 16'h0000, 1'b0, 1'b0, 1'b0}},
            '{'{OPC_TICK,    4'h0, 16'h0000, 24'h000000, 1'b0, 3'd2, 1'b0}, 1'b1,
              '{KIND_DISPATCH, 4'hA, 16'hAAAA, 1'b0, 1'b0, 1'b1}},
            '{'{OPC_UNMAP,   4'h2, 16'h5555, 24'h000000, 1'b0, 3'd0, 1'b0}, 1'b1,
              '{KIND_CANCEL, 4'h2, 16'h5555, 1'b0, 1'b0, 1'b1}}
        };
        foreach (rows[i])
            send_word(rows[i].w, rows[i].typed, rows[i].t);

        // Fill both queues past their depth so that one request of each is
        // dropped, drain them with full ticks (which also overflows the
        // in-flight set), then unmap every probe.
        for (int q = 0; q < 2; q++) begin
            for (int i = 0; i <= QDEPTH; i++) begin
                fw = '{OPC_REQUEST, 4'($urandom), 16'(i + 256 * q), 24'($urandom),
                       1'(q), 3'd0, 1'b0};
                fill_keys.push_back({fw.world, fw.probe});
                send_plain(fw);
            end
        end
        repeat (17) begin
            fw = '{OPC_TICK, 4'($urandom), 16'($urandom), 24'($urandom), 1'b0, 3'd4,
                   1'($urandom)};
            send_plain(fw);
        end
        foreach (fill_keys[i]) begin
            fw = '{OPC_UNMAP, fill_keys[i][19:16], fill_keys[i][15:0], 24'd0, 1'b0,
                   3'd0, 1'b0};
            send_plain(fw);
        end

        // Random phases under the reset gain and then the extremes and a
        // random setting; the sender waits for every result in between.
        random_phase(50);
        drain();
        write_gain(16'd0);
        random_phase(50);
        drain();
        write_gain(16'hFFFF);
        random_phase(50);
        drain();
        write_gain(16'($urandom));
        random_phase(50);
        drain();

        if (errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
